### design/nac_pkg.sv
package nac_pkg;

	localparam int REG_COUNT = 8;
	localparam int REG_SEL_W = $clog2(REG_COUNT);
	localparam int NIBBLE_W  = 4;
	localparam int PC_W      = 8;
	localparam int INSN_W    = 8;

	typedef logic [NIBBLE_W-1:0] nibble_t;
	typedef logic [PC_W-1:0]     pc_t;
	typedef logic [INSN_W-1:0]   insn_t;

	// instruction fields
	localparam int BRANCH_POS = 7;
	localparam int IMM_POS    = 6;
	localparam int STORE_POS  = 3;
	localparam int SIGN_POS   = NIBBLE_W - 1;

	// alu select, opcode bits 5..4
	localparam logic [1:0] ALU_ADD  = 2'd0;
	localparam logic [1:0] ALU_NAND = 2'd1;
	localparam logic [1:0] ALU_XOR  = 2'd2;
	localparam logic [1:0] ALU_MISC = 2'd3;

	// opcode bits 6..4 of the load/store group
	localparam logic [2:0] OPC_LDST = 3'd7;

	// register written by the host
	localparam logic [REG_SEL_W-1:0] HOST_REG = REG_SEL_W'(1);
	// register shown on the output port
	localparam logic [REG_SEL_W-1:0] PORT_REG = REG_SEL_W'(0);

endpackage

### design/nibble_accumulator_core_step_unit.sv
// Nibble accumulator core: executes one 8-bit instruction per transfer on a
// 4-bit accumulator machine with eight 4-bit registers and an 8-bit program
// counter (ADD, NAND, XOR against a register or immediate, LOAD, STORE, and a
// branch taken when accumulator bit 3 is set). After the instruction an
// optional host write puts a nibble in register 1 and an optional restart
// clears the program counter. Each result carries the next program counter,
// the accumulator and register 0. Timing: one instruction per clock
// sustained while the result side keeps taking results; an instruction
// passes through the input register, loaded at the input transfer, and then
// the result register, loaded when the stage advances, from which the result
// is offered. The rate is set by the update of the architectural state (pc,
// accumulator, register file), which the next instruction reads. Reset clears
// pc, accumulator and all registers at once; no clearing pass is needed.
module nibble_accumulator_core_step_unit
	import nac_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	// instruction channel
	input  logic    in_valid,
	output logic    in_ready,
	input  insn_t   instruction,
	input  logic    host_write_valid,
	input  nibble_t host_write_value,
	input  logic    restart_pc,
	// result channel
	output logic    out_valid,
	input  logic    out_ready,
	output pc_t     next_pc,
	output nibble_t accumulator,
	output nibble_t output_port
);

	// input register stage
	logic    valid_s1;
	insn_t   insn_s1;
	logic    hw_valid_s1;
	nibble_t hw_value_s1;
	logic    restart_s1;

	// architectural state
	pc_t     pc_q;
	nibble_t acc_q;
	nibble_t rf_q [REG_COUNT];

	// result register
	logic    out_valid_q;
	pc_t     next_pc_q;
	nibble_t acc_out_q;
	nibble_t port_out_q;

	// execute stage signals
	logic                 advance;
	logic [2:0]           opc;
	logic [REG_SEL_W-1:0] rsel;
	nibble_t              operand;
	nibble_t              acc_n;
	pc_t                  pc_n;
	logic                 st_en;
	nibble_t              rf_n [REG_COUNT];

	// the stage moves when it holds an item and the result slot is free or
	// being emptied in this cycle
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			insn_s1     <= instruction;
			hw_valid_s1 <= host_write_valid;
			hw_value_s1 <= host_write_value;
			restart_s1  <= restart_pc;
		end
	end

	// instruction decode and execute
	assign opc  = insn_s1[6:4];
	assign rsel = insn_s1[REG_SEL_W-1:0];

	always_comb begin
		operand = insn_s1[IMM_POS] ? insn_s1[NIBBLE_W-1:0] : rf_q[rsel];
		acc_n   = acc_q;
		pc_n    = pc_q + PC_W'(1);
		st_en   = 1'b0;
		if (insn_s1[BRANCH_POS]) begin
			// branch on accumulator sign, target is the low seven bits
			if (acc_q[SIGN_POS]) begin
				pc_n = PC_W'(insn_s1[BRANCH_POS-1:0]);
			end
		end else begin
			case (opc[1:0])
				ALU_ADD:  acc_n = acc_q + operand;
				ALU_NAND: acc_n = ~(acc_q & operand);
				ALU_XOR:  acc_n = acc_q ^ operand;
				ALU_MISC: begin
					// load/store group; the other code here is a no-op
					if (opc == OPC_LDST) begin
						if (insn_s1[STORE_POS]) begin
							st_en = 1'b1;
						end else begin
							acc_n = rf_q[rsel];
						end
					end
				end
				default: acc_n = acc_q;
			endcase
		end
		if (restart_s1) begin
			pc_n = '0;
		end
	end

	// register file next value: store first, host write to register 1 wins
	always_comb begin
		for (int i = 0; i < REG_COUNT; i++) begin
			rf_n[i] = rf_q[i];
			if (st_en && rsel == REG_SEL_W'(i)) begin
				rf_n[i] = acc_q;
			end
			if (hw_valid_s1 && HOST_REG == REG_SEL_W'(i)) begin
				rf_n[i] = hw_value_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			acc_q <= '0;
			for (int i = 0; i < REG_COUNT; i++) begin
				rf_q[i] <= '0;
			end
		end else if (advance) begin
			pc_q  <= pc_n;
			acc_q <= acc_n;
			for (int i = 0; i < REG_COUNT; i++) begin
				rf_q[i] <= rf_n[i];
			end
		end
	end

	// result register, loaded together with the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			next_pc_q  <= pc_n;
			acc_out_q  <= acc_n;
			port_out_q <= rf_n[PORT_REG];
		end
	end

	assign out_valid   = out_valid_q;
	assign next_pc     = next_pc_q;
	assign accumulator = acc_out_q;
	assign output_port = port_out_q;

`ifndef NO_ASSERTIONS
	// a waiting result always mirrors the current state
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (next_pc_q == pc_q && acc_out_q == acc_q &&
		port_out_q == rf_q[PORT_REG]))
		else $error("result register out of step with state");

	// restart forces the program counter to zero
	a_restart_clears_pc: assert property (@(posedge clk) disable iff (!arst_n)
		advance && restart_s1 |=> pc_q == '0)
		else $error("restart did not clear pc");

	// host write lands in register 1 whatever the instruction did
	a_host_write_wins: assert property (@(posedge clk) disable iff (!arst_n)
		advance && hw_valid_s1 |=> rf_q[HOST_REG] == $past(hw_value_s1))
		else $error("host write lost");

	// a stalled full pipe takes no new item
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input accepted while pipeline blocked");
`endif

endmodule

### test/tb_nibble_accumulator_core_step_unit.sv
module tb_nibble_accumulator_core_step_unit;
	import nac_pkg::*;

	// cycles without any transfer before the run is declared hung
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	// settle time after the last result
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam int unsigned DIRECTED_N     = 20;
	// random part: free programs, then a branch-free run long enough to wrap the pc
	localparam int unsigned FREE_RUN_A     = 500;
	localparam int unsigned STRAIGHT_RUN   = 320;
	localparam int unsigned FREE_RUN_B     = 510;

	// one instruction transfer, with an optional hand-typed expectation
	typedef struct packed {
		insn_t   instruction;
		logic    host_write_valid;
		nibble_t host_write_value;
		logic    restart_pc;
		logic    typed;
		pc_t     pc;
		nibble_t acc;
		nibble_t port;
	} step_row_t;

	// what one result transfer carries
	typedef struct packed {
		pc_t     pc;
		nibble_t acc;
		nibble_t port;
	} core_view_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	insn_t   instruction;
	logic    host_write_valid;
	nibble_t host_write_value;
	logic    restart_pc;
	logic    out_valid;
	logic    out_ready;
	pc_t     next_pc;
	nibble_t accumulator;
	nibble_t output_port;

	// expectation travelling with the payload, used only by typed rows
	logic       row_typed;
	core_view_t row_expected;

	// architectural state as the testbench sees it
	pc_t     arch_pc;
	nibble_t arch_acc;
	nibble_t arch_regs [REG_COUNT];

	core_view_t  pending_views [$];
	step_row_t   directed_rows [DIRECTED_N];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned burst_left     = 0;

	always #4 clk = ~clk;

	nibble_accumulator_core_step_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.instruction      (instruction),
		.host_write_valid (host_write_valid),
		.host_write_value (host_write_value),
		.restart_pc       (restart_pc),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.next_pc          (next_pc),
		.accumulator      (accumulator),
		.output_port      (output_port)
	);

	// executes one instruction on the architectural copy and returns the new view
	function automatic core_view_t execute_insn(insn_t ins, logic hw_valid, nibble_t hw_value,
			logic restart);
		logic [2:0]           opc;
		logic [REG_SEL_W-1:0] sel;
		nibble_t              operand;
		pc_t                  pc_next;
		core_view_t           view;
		pc_next = arch_pc + PC_W'(1);
		sel     = ins[REG_SEL_W-1:0];
		opc     = ins[6:4];
		if (ins[BRANCH_POS]) begin
			// taken only on a negative accumulator, target is the low seven bits
			if (arch_acc[SIGN_POS])
				pc_next = {1'b0, ins[BRANCH_POS-1:0]};
		end else begin
			// register operands ignore bit 3
			operand = ins[IMM_POS] ? ins[NIBBLE_W-1:0] : arch_regs[sel];
			case (opc[1:0])
				ALU_ADD:  arch_acc = arch_acc + operand;
				ALU_NAND: arch_acc = ~(arch_acc & operand);
				ALU_XOR:  arch_acc = arch_acc ^ operand;
				default: begin
					// opcode 3 does nothing but advance the pc
					if (opc == OPC_LDST) begin
						if (ins[STORE_POS])
							arch_regs[sel] = arch_acc;
						else
							arch_acc = arch_regs[sel];
					end
				end
			endcase
		end
		arch_pc = pc_next;
		// host write lands after the store, so it wins on register 1
		if (hw_valid)
			arch_regs[HOST_REG] = hw_value;
		// restart is applied last
		if (restart)
			arch_pc = '0;
		view.pc   = arch_pc;
		view.acc  = arch_acc;
		view.port = arch_regs[PORT_REG];
		return view;
	endfunction

	// random instruction; branch_free keeps the pc counting up without restarts
	function automatic step_row_t random_step(logic branch_free);
		step_row_t   row;
		int unsigned kind;
		logic [1:0]  alu_sel;
		kind    = $urandom_range(0, 15);
		alu_sel = 2'($urandom_range(0, 2));
		row     = '0;
		if (kind < 4)
			row.instruction = {2'b00, alu_sel, 4'($urandom)};
		else if (kind < 8)
			row.instruction = {2'b01, alu_sel, 4'($urandom)};
		else if (kind < 11)
			row.instruction = {1'b0, OPC_LDST, 4'($urandom)};
		else if (kind < 12)
			row.instruction = {2'b00, ALU_MISC, 4'($urandom)};
		else if (kind < 14)
			row.instruction = 8'($urandom) | (8'd1 << BRANCH_POS);
		else
			row.instruction = 8'($urandom);
		if (branch_free)
			row.instruction[BRANCH_POS] = 1'b0;
		row.host_write_valid = ($urandom_range(0, 3) == 0);
		row.host_write_value = 4'($urandom);
		row.restart_pc       = !branch_free && ($urandom_range(0, 39) == 0);
		return row;
	endfunction

	// offers one instruction, idling first when the current burst is spent
	task automatic offer_step(step_row_t row);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// now and then a long burst with no idling at all
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
		end
		burst_left--;
		in_valid         <= 1'b1;
		instruction      <= row.instruction;
		host_write_valid <= row.host_write_valid;
		host_write_value <= row.host_write_value;
		restart_pc       <= row.restart_pc;
		row_typed        <= row.typed;
		row_expected     <= '{row.pc, row.acc, row.port};
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// predict on each instruction transfer, check each result transfer
	always @(posedge clk) begin : transfer_monitor
		core_view_t predicted;
		core_view_t want;
		if (arst_n && in_valid && in_ready) begin
			predicted = execute_insn(instruction, host_write_valid, host_write_value, restart_pc);
			pending_views.push_back(row_typed ? row_expected : predicted);
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_views.size() == 0) begin
				$error("result with nothing pending: next_pc %0h accumulator %0h output_port %0h",
					next_pc, accumulator, output_port);
				mismatch_count++;
			end else begin
				want = pending_views.pop_front();
				if (next_pc !== want.pc) begin
					$error("next_pc: expected %0h, got %0h", want.pc, next_pc);
					mismatch_count++;
				end
				if (accumulator !== want.acc) begin
					$error("accumulator: expected %0h, got %0h", want.acc, accumulator);
					mismatch_count++;
				end
				if (output_port !== want.port) begin
					$error("output_port: expected %0h, got %0h", want.port, output_port);
					mismatch_count++;
				end
			end
		end
	end

	// hang detection: any transfer on either side resets the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side: segments of free flow, random stalls and fixed patterns,
	// plus long hold-offs so the core fills up and pushes back on its input
	initial begin : result_sink
		int unsigned segment;
		int unsigned kind;
		int unsigned span;
		int unsigned on_len;
		int unsigned off_len;
		int unsigned n;
		out_ready <= 1'b0;
		segment = 0;
		wait (arst_n === 1'b1);
		forever begin
			kind    = $urandom_range(0, 11);
			span    = $urandom_range(20, 150);
			on_len  = $urandom_range(1, 5);
			off_len = $urandom_range(1, 4);
			if (segment == 3 || kind == 0) begin
				// long hold-off, the sender keeps offering meanwhile
				out_ready <= 1'b0;
				repeat ($urandom_range(60, 100)) @(posedge clk);
			end else begin
				for (n = 0; n < span; n++) begin
					if (kind < 4)
						out_ready <= 1'b1;
					else if (kind < 8)
						out_ready <= ($urandom_range(0, 2) != 0);
					else
						out_ready <= ((n % (on_len + off_len)) < on_len);
					@(posedge clk);
				end
			end
			segment++;
		end
	end

	initial begin
		int unsigned i;
		arst_n           <= 1'b0;
		in_valid         <= 1'b0;
		instruction      <= '0;
		host_write_valid <= 1'b0;
		host_write_value <= '0;
		restart_pc       <= 1'b0;
		row_typed        <= 1'b0;
		row_expected     <= '0;
		arch_pc  = '0;
		arch_acc = '0;
		for (i = 0; i < REG_COUNT; i++)
			arch_regs[i] = '0;

		// instruction, host write, host value, restart, typed, pc, acc, port
		directed_rows = '{
			// unused opcode is a no-operation, both ends of the range
			'{8'h30, 1'b0, 4'h0, 1'b0, 1'b1, 8'h01, 4'h0, 4'h0},
			'{8'h3F, 1'b0, 4'h0, 1'b0, 1'b1, 8'h02, 4'h0, 4'h0},
			// immediates at full scale
			'{8'h4F, 1'b0, 4'h0, 1'b0, 1'b1, 8'h03, 4'hF, 4'h0},
			'{8'h5F, 1'b0, 4'h0, 1'b0, 1'b1, 8'h04, 4'h0, 4'h0},
			'{8'h6F, 1'b0, 4'h0, 1'b0, 1'b1, 8'h05, 4'hF, 4'h0},
			// store to the output port
			'{8'h78, 1'b0, 4'h0, 1'b0, 1'b1, 8'h06, 4'hF, 4'hF},
			// taken branch to the top target
			'{8'hFF, 1'b0, 4'h0, 1'b0, 1'b1, 8'h7F, 4'hF, 4'hF},
			'{8'h41, 1'b0, 4'h0, 1'b0, 1'b1, 8'h80, 4'h0, 4'hF},
			// untaken branch only advances the pc
			'{8'h80, 1'b0, 4'h0, 1'b0, 1'b1, 8'h81, 4'h0, 4'hF},
			// store to register 1 alongside a host write, host value wins
			'{8'h79, 1'b1, 4'hA, 1'b0, 1'b1, 8'h82, 4'h0, 4'hF},
			// register operands, some with bit 3 set
			'{8'h09, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, 4'h0, 4'h0},
			'{8'h1A, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, 4'h0, 4'h0},
			'{8'h20, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, 4'h0, 4'h0},
			'{8'h71, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, 4'h0, 4'h0},
			'{8'h7F, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, 4'h0, 4'h0},
			// restart, on a plain add and on a taken branch
			'{8'h00, 1'b0, 4'h0, 1'b1, 1'b0, 8'h00, 4'h0, 4'h0},
			'{8'h8A, 1'b0, 4'h0, 1'b1, 1'b0, 8'h00, 4'h0, 4'h0},
			// host write of zero, then read back what the store left
			'{8'h47, 1'b1, 4'h0, 1'b0, 1'b0, 8'h00, 4'h0, 4'h0},
			'{8'h77, 1'b0, 4'h0, 1'b0, 1'b0, 8'h00, 4'h0, 4'h0},
			'{8'h0F, 1'b1, 4'hF, 1'b0, 1'b0, 8'h00, 4'h0, 4'h0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_N; i++)
			offer_step(directed_rows[i]);
		for (i = 0; i < FREE_RUN_A; i++)
			offer_step(random_step(1'b0));
		// no branches or restarts here, so the pc climbs through 255 and wraps
		for (i = 0; i < STRAIGHT_RUN; i++)
			offer_step(random_step(1'b1));
		for (i = 0; i < FREE_RUN_B; i++)
			offer_step(random_step(1'b0));
		in_valid <= 1'b0;

		// the watchdog catches a result that never turns up
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
